>>> sv/tgcr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph color resolver package
// Shared types, constants and color-table functions of the resolver blocks.
// ----------------------------------------------------------------------------
package tgcr_pkg;

   // Default sizes.
   localparam int EXTRA_COLORS_DEFAULT = 8;
   localparam int CMD_QUEUE_DEPTH      = 4;
   localparam int RSP_QUEUE_DEPTH      = 2;

   // Request operation codes.
   localparam logic OP_RESOLVE = 1'b0;
   localparam logic OP_WRITE   = 1'b1;

   // Control and status register map.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_DEFAULT_FG  = 2'd0;
   localparam logic [1:0] REG_DEFAULT_BG  = 2'd1;
   localparam logic [1:0] REG_BG_ALPHA    = 2'd2;
   localparam logic [1:0] REG_REVERSE_VID = 2'd3;

   localparam logic [8:0] DEFAULT_FG_RESET = 9'd258;
   localparam logic [8:0] DEFAULT_BG_RESET = 9'd259;
   localparam logic [7:0] BG_ALPHA_RESET   = 8'd255;

   // Computed palette constants.
   localparam logic [15:0] CUBE_BASE = 16'h3737;
   localparam logic [15:0] CUBE_STEP = 16'h2828;
   localparam logic [15:0] GREY_BASE = 16'h0808;
   localparam logic [15:0] GREY_STEP = 16'h0a0a;

   typedef struct packed {
      logic [8:0] default_fg_index;
      logic [8:0] default_bg_index;
      logic [7:0] bg_alpha;
      logic       reverse_video;
   } cfg_type;

   // Where one color comes from and how it is modified.
   typedef struct packed {
      logic        use_mem;    // read from the palette store
      logic [8:0]  index;      // palette index when use_mem is set
      logic [47:0] rgb;        // direct red, green, blue
      logic [7:0]  alpha;      // direct alpha, or bg_alpha when alpha_def
      logic        alpha_def;  // entry is the default background
      logic        invert;
   } color_src_type;

   typedef struct packed {
      logic          is_write;
      logic          wr_en;
      logic [8:0]    wr_index;
      logic [63:0]   wr_value;
      color_src_type fg;
      color_src_type bg;
      logic          halve;
      logic          swap;
      logic          copy;
   } cmd_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [7:0]  alpha;
   } pixel_type;

   typedef struct packed {
      pixel_type fg;
      pixel_type bg;
   } rsp_type;

   function automatic logic [15:0] cube_level(input logic [2:0] x);
      logic [15:0] lvl;
      lvl = (x == 3'd0) ? 16'd0 : 16'(CUBE_BASE + CUBE_STEP * 16'(x));
      return lvl;
   endfunction

   // Channels of a 6x6x6 cube entry; k is the index less 16 (0..215).
   function automatic logic [47:0] cube_rgb(input logic [7:0] k);
      logic [2:0] r;
      logic [2:0] g;
      logic [2:0] b;
      logic [7:0] rem;
      r = 3'd0;
      g = 3'd0;
      for (int i = 1; i < 6; i++) begin
         if (k >= 8'(36 * i)) r = 3'(i);
      end
      rem = 8'(k - 8'(r) * 8'd36);
      for (int i = 1; i < 6; i++) begin
         if (rem >= 8'(6 * i)) g = 3'(i);
      end
      b = 3'(rem - 8'(g) * 8'd6);
      return {cube_level(r), cube_level(g), cube_level(b)};
   endfunction

   function automatic logic [15:0] grey_level(input logic [4:0] n);
      return 16'(GREY_BASE + GREY_STEP * 16'(n));
   endfunction

endpackage

>>> sv/terminal_glyph_color_resolver_unit.sv
// ----------------------------------------------------------------------------
// Terminal glyph color resolver
// Resolves the foreground and background colors of text cells against a
// writable base palette, the computed 256-color tables and cell attributes.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle for as long as the result side
// keeps popping. A resolve request passes through the command queue between
// the classifying front end and the back end, the registered read of the
// palette store and the result queue before its result shows on the rsp_
// ports. A palette write produces no result and is visible to every later
// request. Stored palette entries must be written before a request reads them.
// Configuration registers may only be written while no request is in flight.
module terminal_glyph_color_resolver_unit
   import tgcr_pkg::*;
#(
   parameter int EXTRA_COLORS = EXTRA_COLORS_DEFAULT,
   parameter int CMD_DEPTH    = CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH    = RSP_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_operation,
   input  logic [24:0]           req_fg_color,
   input  logic [24:0]           req_bg_color,
   input  logic                  req_bold,
   input  logic                  req_faint,
   input  logic                  req_reverse_attr,
   input  logic                  req_blink,
   input  logic                  req_invisible,
   input  logic                  req_blink_phase,
   input  logic [8:0]            req_palette_index,
   input  logic [63:0]           req_palette_value,
   // Result channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [15:0]           rsp_fg_red,
   output logic [15:0]           rsp_fg_green,
   output logic [15:0]           rsp_fg_blue,
   output logic [7:0]            rsp_fg_alpha,
   output logic [15:0]           rsp_bg_red,
   output logic [15:0]           rsp_bg_green,
   output logic [15:0]           rsp_bg_blue,
   output logic [7:0]            rsp_bg_alpha_out,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [8:0] default_fg_ff, default_fg_in;
   logic [8:0] default_bg_ff, default_bg_in;
   logic [7:0] bg_alpha_ff, bg_alpha_in;
   logic       reverse_video_ff, reverse_video_in;
   logic       csr_write;
   logic [1:0] csr_index;
   cfg_type    cfg;

   cmd_type    front_cmd, back_cmd;
   logic [CMD_W-1:0] cmd_q_data;
   logic       cmd_q_empty, cmd_pop;
   logic       rsp_push, rsp_q_full;
   rsp_type    back_rsp, rsp_head;
   logic [RSP_W-1:0] rsp_q_data;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      default_fg_in    = default_fg_ff;
      default_bg_in    = default_bg_ff;
      bg_alpha_in      = bg_alpha_ff;
      reverse_video_in = reverse_video_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DEFAULT_FG:  default_fg_in    = csr_pwdata[8:0];
            REG_DEFAULT_BG:  default_bg_in    = csr_pwdata[8:0];
            REG_BG_ALPHA:    bg_alpha_in      = csr_pwdata[7:0];
            REG_REVERSE_VID: reverse_video_in = csr_pwdata[0];
            default:         default_fg_in    = default_fg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEFAULT_FG:  csr_prdata = CSR_DATA_W'(default_fg_ff);
         REG_DEFAULT_BG:  csr_prdata = CSR_DATA_W'(default_bg_ff);
         REG_BG_ALPHA:    csr_prdata = CSR_DATA_W'(bg_alpha_ff);
         REG_REVERSE_VID: csr_prdata = CSR_DATA_W'(reverse_video_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff    <= DEFAULT_FG_RESET;
         default_bg_ff    <= DEFAULT_BG_RESET;
         bg_alpha_ff      <= BG_ALPHA_RESET;
         reverse_video_ff <= 1'b0;
      end else begin
         default_fg_ff    <= default_fg_in;
         default_bg_ff    <= default_bg_in;
         bg_alpha_ff      <= bg_alpha_in;
         reverse_video_ff <= reverse_video_in;
      end
   end

   assign cfg.default_fg_index = default_fg_ff;
   assign cfg.default_bg_index = default_bg_ff;
   assign cfg.bg_alpha         = bg_alpha_ff;
   assign cfg.reverse_video    = reverse_video_ff;

   tgcr_front #(
      .EXTRA_COLORS (EXTRA_COLORS)
   ) u_front (
      .cfg               (cfg),
      .req_operation     (req_operation),
      .req_fg_color      (req_fg_color),
      .req_bg_color      (req_bg_color),
      .req_bold          (req_bold),
      .req_faint         (req_faint),
      .req_reverse_attr  (req_reverse_attr),
      .req_blink         (req_blink),
      .req_invisible     (req_invisible),
      .req_blink_phase   (req_blink_phase),
      .req_palette_index (req_palette_index),
      .req_palette_value (req_palette_value),
      .cmd               (front_cmd)
   );

   tgcr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .pop       (cmd_pop),
      .pop_data  (cmd_q_data),
      .full      (req_full),
      .empty     (cmd_q_empty)
   );

   assign back_cmd = cmd_type'(cmd_q_data);

   tgcr_back #(
      .EXTRA_COLORS (EXTRA_COLORS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (!cmd_q_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp),
      .rsp_full  (rsp_q_full)
   );

   tgcr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_data),
      .full      (rsp_q_full),
      .empty     (rsp_empty)
   );

   assign rsp_head         = rsp_type'(rsp_q_data);
   assign rsp_fg_red       = rsp_head.fg.red;
   assign rsp_fg_green     = rsp_head.fg.green;
   assign rsp_fg_blue      = rsp_head.fg.blue;
   assign rsp_fg_alpha     = rsp_head.fg.alpha;
   assign rsp_bg_red       = rsp_head.bg.red;
   assign rsp_bg_green     = rsp_head.bg.green;
   assign rsp_bg_blue      = rsp_head.bg.blue;
   assign rsp_bg_alpha_out = rsp_head.bg.alpha;

   // The back end never pushes a result into a full result queue.
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_q_full)
      else $error("result pushed into full queue");

   // The back end only takes a request that is waiting in the command queue.
   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_q_empty)
      else $error("command popped from empty queue");

   // Reset leaves no result waiting and room for a request.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not cleared by reset");

endmodule

>>> sv/tgcr_fifo.sv
// ----------------------------------------------------------------------------
// Resolver queue
// Small first-in first-out queue of fixed-width words with full and empty.
// ----------------------------------------------------------------------------
module tgcr_fifo
   import tgcr_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/tgcr_front.sv
// ----------------------------------------------------------------------------
// Resolver front end
// Classifies each request: decides which palette entry or direct color each
// side takes, and which attribute modifications the back end applies.
// ----------------------------------------------------------------------------
module tgcr_front
   import tgcr_pkg::*;
#(
   parameter int EXTRA_COLORS = EXTRA_COLORS_DEFAULT
) (
   input  cfg_type      cfg,
   input  logic         req_operation,
   input  logic [24:0]  req_fg_color,
   input  logic [24:0]  req_bg_color,
   input  logic         req_bold,
   input  logic         req_faint,
   input  logic         req_reverse_attr,
   input  logic         req_blink,
   input  logic         req_invisible,
   input  logic         req_blink_phase,
   input  logic [8:0]   req_palette_index,
   input  logic [63:0]  req_palette_value,
   output cmd_type      cmd
);

   logic        bold_eff;
   logic        fg_pal, bg_pal;
   logic [23:0] fg_idx0, fg_idx, bg_idx;
   logic        fg_to_def, bg_to_def;

   function automatic color_src_type classify(input logic pal, input logic [23:0] idx,
                                              input cfg_type c);
      color_src_type s;
      logic [15:0]   lvl;
      s   = '0;
      lvl = '0;
      if (!pal) begin
         s.rgb   = {idx[23:16], 8'h00, idx[15:8], 8'h00, idx[7:0], 8'h00};
         s.alpha = 8'hFF;
      end else if (idx < 24'd16) begin
         s.use_mem = 1'b1;
      end else if (idx < 24'd232) begin
         s.rgb   = cube_rgb(8'(idx - 24'd16));
         s.alpha = 8'hFF;
      end else if (idx < 24'd256) begin
         lvl     = grey_level(5'(idx - 24'd232));
         s.rgb   = {lvl, lvl, lvl};
         s.alpha = 8'hFF;
      end else if (idx < 24'(256 + EXTRA_COLORS)) begin
         s.use_mem = 1'b1;
      end
      s.index = idx[8:0];
      if (pal && idx == {15'd0, c.default_bg_index}) begin
         s.alpha     = c.bg_alpha;
         s.alpha_def = 1'b1;
      end
      return s;
   endfunction

   always_comb begin
      bold_eff = req_bold && !req_faint && (req_fg_color[24:3] == '0);
      fg_pal   = !req_fg_color[24];
      bg_pal   = !req_bg_color[24];
      fg_idx0  = bold_eff ? {20'd0, 1'b1, req_fg_color[2:0]} : req_fg_color[23:0];

      // Under reverse video the default colors trade places; all else inverts.
      fg_to_def = cfg.reverse_video && fg_pal && (fg_idx0 == {15'd0, cfg.default_fg_index});
      bg_to_def = cfg.reverse_video && bg_pal &&
                  (req_bg_color[23:0] == {15'd0, cfg.default_bg_index});
      fg_idx = fg_to_def ? {15'd0, cfg.default_bg_index} : fg_idx0;
      bg_idx = bg_to_def ? {15'd0, cfg.default_fg_index} : req_bg_color[23:0];

      cmd           = '0;
      cmd.is_write  = (req_operation == OP_WRITE);
      cmd.wr_index  = req_palette_index;
      cmd.wr_value  = req_palette_value;
      cmd.wr_en     = (req_palette_index < 9'd16) ||
                      (req_palette_index >= 9'd256 &&
                       req_palette_index < 9'(256 + EXTRA_COLORS));
      cmd.fg        = classify(fg_pal, fg_idx, cfg);
      cmd.bg        = classify(bg_pal, bg_idx, cfg);
      cmd.fg.invert = cfg.reverse_video && !fg_to_def;
      cmd.bg.invert = cfg.reverse_video && !bg_to_def;
      cmd.halve     = req_faint && !req_bold;
      cmd.swap      = req_reverse_attr;
      cmd.copy      = (req_blink && req_blink_phase) || req_invisible;
   end

endmodule

>>> sv/tgcr_back.sv
// ----------------------------------------------------------------------------
// Resolver back end
// Holds the palette store, carries out writes and reads, and builds the
// final foreground and background colors of each resolve request.
// ----------------------------------------------------------------------------
module tgcr_back
   import tgcr_pkg::*;
#(
   parameter int EXTRA_COLORS = EXTRA_COLORS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp,
   input  logic    rsp_full
);

   localparam int PAL_DEPTH = 16 + EXTRA_COLORS;
   localparam int ADDR_W    = $clog2(PAL_DEPTH);

   logic [63:0]  pal_mem [PAL_DEPTH];
   logic [63:0]  rd_fg_ff, rd_bg_ff;
   logic         b_valid_ff, b_valid_in;
   logic         b_result_ff, b_result_in;
   cmd_type      b_cmd_ff, b_cmd_in;
   logic         issue, b_advance;
   logic [ADDR_W-1:0] wr_addr, fg_addr, bg_addr;
   pixel_type    fg_pix, bg_pix;

   function automatic logic [ADDR_W-1:0] slot(input logic [8:0] index);
      logic [8:0] off;
      off = index - 9'd240;
      return (index < 9'd16) ? ADDR_W'(index[3:0]) : ADDR_W'(off);
   endfunction

   function automatic pixel_type build(input color_src_type c, input logic [63:0] rd);
      pixel_type p;
      p.red   = c.rgb[47:32];
      p.green = c.rgb[31:16];
      p.blue  = c.rgb[15:0];
      p.alpha = c.alpha;
      if (c.use_mem) begin
         p.red   = rd[47:32];
         p.green = rd[31:16];
         p.blue  = rd[15:0];
         if (!c.alpha_def) p.alpha = rd[55:48];
      end
      if (c.invert) begin
         p.red   = ~p.red;
         p.green = ~p.green;
         p.blue  = ~p.blue;
      end
      return p;
   endfunction

   assign b_advance = b_valid_ff && (!b_result_ff || !rsp_full);
   assign issue     = cmd_valid && (!b_valid_ff || b_advance);
   assign cmd_pop   = issue;
   assign rsp_push  = b_valid_ff && b_result_ff && !rsp_full;

   assign wr_addr = cmd.wr_en ? slot(cmd.wr_index) : '0;
   assign fg_addr = cmd.fg.use_mem ? slot(cmd.fg.index) : '0;
   assign bg_addr = cmd.bg.use_mem ? slot(cmd.bg.index) : '0;

   always_comb begin
      b_valid_in  = b_valid_ff;
      b_result_in = b_result_ff;
      b_cmd_in    = b_cmd_ff;
      if (issue) begin
         b_valid_in  = 1'b1;
         b_result_in = !cmd.is_write;
         b_cmd_in    = cmd;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         b_result_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         b_result_ff <= b_result_in;
      end
      b_cmd_ff <= b_cmd_in;
   end

   // Requests issue in order, so a read always sees every earlier write.
   always_ff @(posedge clock) begin
      if (issue && cmd.is_write && cmd.wr_en) begin
         pal_mem[wr_addr] <= cmd.wr_value;
      end
      if (issue) begin
         rd_fg_ff <= pal_mem[fg_addr];
         rd_bg_ff <= pal_mem[bg_addr];
      end
   end

   always_comb begin
      fg_pix = build(b_cmd_ff.fg, rd_fg_ff);
      bg_pix = build(b_cmd_ff.bg, rd_bg_ff);
      if (b_cmd_ff.halve) begin
         fg_pix.red   = fg_pix.red >> 1;
         fg_pix.green = fg_pix.green >> 1;
         fg_pix.blue  = fg_pix.blue >> 1;
      end
      rsp.bg = b_cmd_ff.swap ? fg_pix : bg_pix;
      if (b_cmd_ff.copy) begin
         rsp.fg = rsp.bg;
      end else begin
         rsp.fg = b_cmd_ff.swap ? bg_pix : fg_pix;
      end
   end

endmodule
